### rtl/sktu_pkg.sv
// types, constants and codes shared by the sorted key table blocks
`default_nettype none

package sktu_pkg;

  localparam int unsigned TABLE_DEPTH = 32;
  localparam int unsigned IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_READ   = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_UPDATED   = 3'd1,
    ST_DELETED   = 3'd2,
    ST_NOTFOUND  = 3'd3,
    ST_FULL      = 3'd4,
    ST_READOK    = 3'd5,
    ST_READEMPTY = 3'd6
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_SRCH,
    S_CMP,
    S_INS_RD,
    S_INS_WR,
    S_DEL_RD,
    S_DEL_WR,
    S_READ,
    S_RESULT
  } state_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] key;
    logic [1:0]  entry_kind;
    logic [31:0] target_number;
    logic [7:0]  restriction;
    logic [4:0]  position;
  } in_t;

  typedef struct packed {
    status_e     status;
    logic [5:0]  entry_count;
    logic [15:0] out_key;
    logic [1:0]  out_kind;
    logic [31:0] out_target;
    logic [7:0]  out_restriction;
  } out_t;

  typedef struct packed {
    logic [15:0] key;
    logic [1:0]  kind;
    logic [31:0] target;
    logic [7:0]  restriction;
  } entry_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic [IDX_W-1:0] raddr;
  } ram_req_t;

  typedef struct packed {
    logic valid;
    out_t result;
  } push_t;

endpackage

`default_nettype wire

### rtl/sktu_ram.sv
// generic single write port ram with registered read
`default_nettype none

module sktu_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                                        clk_i,
  input  wire logic                                        we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                            wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

### rtl/sktu_seq.sv
// sequencer: key search, entry shifting and result build over the table ram
`default_nettype none

module sktu_seq (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire sktu_pkg::in_t     in_data_i,
  output sktu_pkg::ram_req_t     ram_req_o,
  input  wire sktu_pkg::entry_t  ram_rdata_i,
  output sktu_pkg::push_t        push_o,
  input  wire logic              push_ready_i
);

  import sktu_pkg::*;

  state_e           state_q, state_d;
  in_t              item_q, item_d;
  logic [CNT_W-1:0] i_q, i_d;
  logic [CNT_W-1:0] j_q, j_d;
  logic [CNT_W-1:0] count_q, count_d;
  out_t             res_q, res_d;
  logic [CNT_W-1:0] j_inc, j_dec;
  entry_t           new_entry;
  logic             decide, hit, fin;
  status_e          fin_status;
  entry_t           fin_entry;

  assign j_inc = j_q + CNT_W'(1);
  assign j_dec = j_q - CNT_W'(1);
  assign new_entry = '{key: item_q.key, kind: item_q.entry_kind,
                       target: item_q.target_number, restriction: item_q.restriction};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    i_q    <= i_d;
    j_q    <= j_d;
    res_q  <= res_d;
  end

  always_comb begin
    state_d    = state_q;
    item_d     = item_q;
    i_d        = i_q;
    j_d        = j_q;
    count_d    = count_q;
    res_d      = res_q;
    decide     = 1'b0;
    hit        = 1'b0;
    fin        = 1'b0;
    fin_status = ST_READEMPTY;
    fin_entry  = '0;
    ram_req_o  = '{we: 1'b0, waddr: i_q[IDX_W-1:0], wdata: ram_rdata_i,
                   raddr: i_q[IDX_W-1:0]};
    in_stall_o = (state_q != S_IDLE);
    push_o     = '{valid: 1'b0, result: res_q};

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          item_d  = in_data_i;
          state_d = S_START;
        end
      end
      S_START: begin
        i_d = '0;
        case (item_q.cmd)
          CMD_INSERT, CMD_DELETE: begin
            state_d = S_SRCH;
          end
          CMD_READ: begin
            if (32'(item_q.position) < 32'(count_q)) begin
              ram_req_o.raddr = IDX_W'(item_q.position);
              state_d         = S_READ;
            end else begin
              fin = 1'b1;
            end
          end
          default: begin
            fin = 1'b1;
          end
        endcase
      end
      S_SRCH: begin
        if (i_q == count_q) begin
          decide = 1'b1;
        end else begin
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        if (ram_rdata_i.key < item_q.key) begin
          i_d     = i_q + CNT_W'(1);
          state_d = S_SRCH;
        end else begin
          decide = 1'b1;
          hit    = (ram_rdata_i.key == item_q.key);
        end
      end
      S_INS_RD: begin
        if (j_q == i_q) begin
          ram_req_o.we    = 1'b1;
          ram_req_o.wdata = new_entry;
          count_d         = count_q + CNT_W'(1);
          fin             = 1'b1;
          fin_status      = ST_INSERTED;
        end else begin
          ram_req_o.raddr = j_dec[IDX_W-1:0];
          state_d         = S_INS_WR;
        end
      end
      S_INS_WR: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = j_q[IDX_W-1:0];
        j_d             = j_dec;
        state_d         = S_INS_RD;
      end
      S_DEL_RD: begin
        if (j_inc >= count_q) begin
          count_d    = count_q - CNT_W'(1);
          fin        = 1'b1;
          fin_status = ST_DELETED;
        end else begin
          ram_req_o.raddr = j_inc[IDX_W-1:0];
          state_d         = S_DEL_WR;
        end
      end
      S_DEL_WR: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = j_q[IDX_W-1:0];
        j_d             = j_inc;
        state_d         = S_DEL_RD;
      end
      S_READ: begin
        fin        = 1'b1;
        fin_status = ST_READOK;
        fin_entry  = ram_rdata_i;
      end
      S_RESULT: begin
        push_o.valid = 1'b1;
        if (push_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (decide) begin
      if (item_q.cmd == CMD_INSERT) begin
        if (hit) begin
          ram_req_o.we    = 1'b1;
          ram_req_o.wdata = '{key: item_q.key, kind: item_q.entry_kind,
                              target: item_q.target_number,
                              restriction: ram_rdata_i.restriction};
          fin             = 1'b1;
          fin_status      = ST_UPDATED;
        end else if (32'(count_q) >= TABLE_DEPTH) begin
          fin        = 1'b1;
          fin_status = ST_FULL;
        end else begin
          j_d     = count_q;
          state_d = S_INS_RD;
        end
      end else begin
        if (hit) begin
          j_d     = i_q;
          state_d = S_DEL_RD;
        end else begin
          fin        = 1'b1;
          fin_status = ST_NOTFOUND;
        end
      end
    end

    if (fin) begin
      state_d = S_RESULT;
      res_d   = '{status: fin_status, entry_count: 6'(count_d),
                  out_key: fin_entry.key, out_kind: fin_entry.kind,
                  out_target: fin_entry.target, out_restriction: fin_entry.restriction};
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= TABLE_DEPTH)
    else $error("entry count above table depth");

  a_ins_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INS_RD) |-> (j_q >= i_q))
    else $error("insert shift passed the insert position");

  a_del_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DEL_RD) |-> (j_q < count_q))
    else $error("delete shift beyond last entry");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RESULT && res_q.status == ST_FULL) |-> (32'(count_q) == TABLE_DEPTH))
    else $error("full reported while table has room");
`endif

endmodule

`default_nettype wire

### rtl/sorted_key_table_upsert.sv
// top level: sorted key table with insert or update, delete and read
//
//   channel | dir | handshake              | payload
//   in      | in  | in_valid_i, in_stall_o   | in_data_i (in_t)
//   out     | out | out_valid_o, out_stall_i | out_data_o (out_t)
//
// per item: insert, update, delete, not found and full search past smaller keys first;
//   insert and delete then shift the entries behind; read, read empty and spare skip the search
// the single table ram port pair (one read, one write a cycle) paces the search and the shifting
// reset clears the entry count, the sequencer state and the output valid; no clearing pass, table contents stay unknown
// the result waits in an output register while the next item runs; a second one holds in seq
`default_nettype none

module sorted_key_table_upsert (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire sktu_pkg::in_t   in_data_i,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output sktu_pkg::out_t       out_data_o
);

  import sktu_pkg::*;

  ram_req_t ram_req;
  entry_t   ram_rdata;
  push_t    push;
  logic     push_ready;
  logic     out_valid_q;
  out_t     out_q;

  sktu_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .raddr_i (ram_req.raddr),
    .rdata_o (ram_rdata)
  );

  sktu_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .ram_req_o    (ram_req),
    .ram_rdata_i  (ram_rdata),
    .push_o       (push),
    .push_ready_i (push_ready)
  );

  assign push_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (push.valid && push_ready) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push.valid && push_ready) begin
      out_q <= push.result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

### bench/sorted_key_table_upsert_tb.sv
// self-checking bench for the sorted key table: directed and random commands against a scoreboard
module sorted_key_table_upsert_tb;
  import sktu_pkg::*;

  localparam logic [1:0]  CMD_SPARE      = 2'd3;
  localparam int unsigned RANDOM_ITEMS   = 1400;
  localparam int unsigned QUIET_ITEMS    = 150;
  localparam int unsigned PHASE_ITEMS    = 120;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned DRAIN_CYCLES   = 200;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned MAX_REPORTS    = 10;

  typedef enum int unsigned {PH_FILL, PH_CHURN, PH_DRAIN, PH_SCATTER} phase_e;

  class sort_table_tracker;
    entry_t      rows[TABLE_DEPTH];
    int unsigned row_count;
    out_t        expected_replies[$];
    int unsigned mismatches;

    function void note_command(in_t c);
      out_t        r;
      int unsigned pos;
      int unsigned j;
      bit          hit;
      r   = '0;
      pos = 0;
      while (pos < row_count && rows[pos].key < c.key) pos++;
      hit = (pos < row_count) && (rows[pos].key == c.key);
      case (c.cmd)
        CMD_INSERT: begin
          if (hit) begin
            rows[pos].kind   = c.entry_kind;
            rows[pos].target = c.target_number;
            r.status = ST_UPDATED;
          end else if (row_count >= TABLE_DEPTH) begin
            r.status = ST_FULL;
          end else begin
            for (j = row_count; j > pos; j--) rows[j] = rows[j-1];
            rows[pos] = '{key: c.key, kind: c.entry_kind, target: c.target_number,
                          restriction: c.restriction};
            row_count++;
            r.status = ST_INSERTED;
          end
        end
        CMD_DELETE: begin
          if (hit) begin
            for (j = pos; j + 1 < row_count; j++) rows[j] = rows[j+1];
            row_count--;
            r.status = ST_DELETED;
          end else begin
            r.status = ST_NOTFOUND;
          end
        end
        CMD_READ: begin
          if (c.position < row_count) begin
            r.status          = ST_READOK;
            r.out_key         = rows[c.position].key;
            r.out_kind        = rows[c.position].kind;
            r.out_target      = rows[c.position].target;
            r.out_restriction = rows[c.position].restriction;
          end else begin
            r.status = ST_READEMPTY;
          end
        end
        default: begin
          r.status = ST_READEMPTY;
        end
      endcase
      r.entry_count = 6'(row_count);
      expected_replies.push_back(r);
    endfunction

    function void check_reply(out_t got);
      out_t want;
      if (expected_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("reply with none pending: st=%0d cnt=%0d key=%h kind=%0d tgt=%h rst=%h",
                   got.status, got.entry_count, got.out_key, got.out_kind, got.out_target,
                   got.out_restriction);
        return;
      end
      want = expected_replies.pop_front();
      if (got.status !== want.status || got.entry_count !== want.entry_count ||
          got.out_key !== want.out_key || got.out_kind !== want.out_kind ||
          got.out_target !== want.out_target ||
          got.out_restriction !== want.out_restriction) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("reply mismatch: exp st=%0d cnt=%0d key=%h kind=%0d tgt=%h rst=%h | got st=%0d cnt=%0d key=%h kind=%0d tgt=%h rst=%h",
                   want.status, want.entry_count, want.out_key, want.out_kind,
                   want.out_target, want.out_restriction, got.status, got.entry_count,
                   got.out_key, got.out_kind, got.out_target, got.out_restriction);
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic in_stall_o;
  in_t  in_data_i   = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_data_o;

  sort_table_tracker tracker = new();

  logic [15:0] key_pool[64];
  int unsigned pool_size   = 1;
  logic        hold_req    = 1'b0;
  logic        quiet       = 1'b0;
  int unsigned stall_left  = 0;
  int unsigned free_left   = 0;
  bit          hold_taken  = 1'b0;
  int unsigned idle_cycles = 0;

  sorted_key_table_upsert u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // receiver: checks replies, random stall bursts, one long hold
  always @(posedge clk_i) begin
    if (out_valid_o === 1'b1 && out_stall_i === 1'b0) tracker.check_reply(out_data_o);
    if (hold_req && !hold_taken) begin
      hold_taken = 1'b1;
      stall_left = HOLD_CYCLES;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (quiet || free_left > 0) begin
      if (free_left > 0) free_left--;
      out_stall_i <= 1'b0;
    end else begin
      stall_left = $urandom_range(1, 18) - 1;
      free_left  = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(0, 12);
      out_stall_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && !out_stall_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  task automatic send_command(input in_t c);
    in_valid_i <= 1'b1;
    in_data_i  <= c;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    tracker.note_command(c);
  endtask

  task automatic sender_pause(input int unsigned n);
    in_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic send_direct(input logic [1:0] cmd, input logic [15:0] key,
                             input logic [1:0] kind, input logic [31:0] tgt,
                             input logic [7:0] restr, input logic [4:0] pos);
    in_t c;
    c = '{cmd: cmd, key: key, entry_kind: kind, target_number: tgt, restriction: restr,
          position: pos};
    send_command(c);
    if ($urandom_range(0, 2) == 0) sender_pause($urandom_range(1, 18));
  endtask

  function automatic void fill_pool(input int unsigned n);
    int unsigned base;
    int unsigned step;
    step = $urandom_range(1, 4);
    base = $urandom_range(0, 65535 - 64 * step);
    for (int unsigned i = 0; i < n; i++) key_pool[i] = 16'(base + i * step);
    pool_size = n;
  endfunction

  function automatic in_t make_command(input phase_e ph);
    in_t         c;
    int unsigned roll;
    int unsigned ins_w;
    int unsigned del_w;
    int unsigned own_w;
    int unsigned lim;
    case (ph)
      PH_FILL:  begin ins_w = 85; del_w = 5;  own_w = 1; end
      PH_DRAIN: begin ins_w = 15; del_w = 65; own_w = 7; end
      default:  begin ins_w = 40; del_w = 30; own_w = 3; end
    endcase
    roll = $urandom_range(0, 99);
    if (roll < ins_w) c.cmd = CMD_INSERT;
    else if (roll < ins_w + del_w) c.cmd = CMD_DELETE;
    else if (roll < 97) c.cmd = CMD_READ;
    else c.cmd = CMD_SPARE;
    roll = $urandom_range(0, 9);
    if (roll < own_w && tracker.row_count > 0)
      c.key = tracker.rows[$urandom_range(0, tracker.row_count - 1)].key;
    else if (roll == 9) c.key = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
    else if (ph == PH_SCATTER) c.key = 16'($urandom());
    else c.key = key_pool[$urandom_range(0, pool_size - 1)];
    c.entry_kind    = 2'($urandom_range(0, 3));
    c.target_number = $urandom();
    c.restriction   = 8'($urandom());
    lim = (tracker.row_count < TABLE_DEPTH) ? tracker.row_count : TABLE_DEPTH - 1;
    c.position = ($urandom_range(0, 3) == 0) ? 5'($urandom()) : 5'($urandom_range(0, lim));
    return c;
  endfunction

  initial begin
    int unsigned sent;
    int unsigned phase_idx;
    int unsigned gap_odds;
    bit          calm;
    phase_e      ph;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_direct(CMD_READ,   16'h0000, 2'd0, 32'h0000_0000, 8'h00, 5'd0);
    send_direct(CMD_READ,   16'h0000, 2'd0, 32'h0000_0000, 8'h00, 5'd31);
    send_direct(CMD_DELETE, 16'h0000, 2'd0, 32'h0000_0000, 8'h00, 5'd0);
    send_direct(CMD_INSERT, 16'h8000, 2'd0, 32'h0000_0000, 8'h00, 5'd0);
    send_direct(CMD_INSERT, 16'h0000, 2'd1, 32'hFFFF_FFFF, 8'hFF, 5'd0);
    send_direct(CMD_INSERT, 16'hFFFF, 2'd2, 32'hA5A5_A5A5, 8'h5A, 5'd0);
    // duplicate key keeps the old restriction
    send_direct(CMD_INSERT, 16'h8000, 2'd3, 32'h1234_5678, 8'h77, 5'd0);
    send_direct(CMD_READ,   16'h0000, 2'd0, 32'h0000_0000, 8'h00, 5'd0);
    send_direct(CMD_READ,   16'h0000, 2'd0, 32'h0000_0000, 8'h00, 5'd1);
    send_direct(CMD_READ,   16'h0000, 2'd0, 32'h0000_0000, 8'h00, 5'd2);
    send_direct(CMD_READ,   16'h0000, 2'd0, 32'h0000_0000, 8'h00, 5'd3);
    send_direct(CMD_SPARE,  16'h1234, 2'd3, 32'hFFFF_FFFF, 8'hFF, 5'd31);
    send_direct(CMD_DELETE, 16'h8001, 2'd0, 32'h0000_0000, 8'h00, 5'd0);
    send_direct(CMD_DELETE, 16'h8000, 2'd0, 32'h0000_0000, 8'h00, 5'd0);
    send_direct(CMD_READ,   16'h0000, 2'd0, 32'h0000_0000, 8'h00, 5'd1);
    send_direct(CMD_DELETE, 16'h0000, 2'd0, 32'h0000_0000, 8'h00, 5'd0);
    send_direct(CMD_INSERT, 16'h7FFF, 2'd1, 32'h5A5A_5A5A, 8'hA5, 5'd0);
    send_direct(CMD_READ,   16'h0000, 2'd0, 32'h0000_0000, 8'h00, 5'd0);
    send_direct(CMD_DELETE, 16'hFFFF, 2'd0, 32'h0000_0000, 8'h00, 5'd0);
    send_direct(CMD_DELETE, 16'h7FFF, 2'd0, 32'h0000_0000, 8'h00, 5'd0);
    send_direct(CMD_READ,   16'h0000, 2'd0, 32'h0000_0000, 8'h00, 5'd0);
    send_direct(CMD_INSERT, 16'h0001, 2'd3, 32'h8000_0001, 8'h80, 5'd0);

    // long receiver hold while the first phase runs without gaps
    hold_req  <= 1'b1;
    sent      = 0;
    phase_idx = 0;
    while (sent < RANDOM_ITEMS) begin
      ph = phase_e'(phase_idx % 4);
      if (ph == PH_FILL) fill_pool(48);
      else if (ph == PH_CHURN) fill_pool(10);
      gap_odds = (phase_idx == 0 || phase_idx % 5 == 3) ? 0 : $urandom_range(2, 6);
      for (int unsigned k = 0; k < PHASE_ITEMS && sent < RANDOM_ITEMS; k++) begin
        calm = (sent >= RANDOM_ITEMS - QUIET_ITEMS);
        quiet <= calm;
        send_command(make_command(ph));
        sent++;
        if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
          sender_pause($urandom_range(1, 18));
      end
      phase_idx++;
    end
    in_valid_i <= 1'b0;

    while (tracker.expected_replies.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.expected_replies.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
